/* rtl/assert_macros.svh */
// Assertion macros used by the top level RTL file of the scalefactor exponent block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while the block is out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion lbl failed");

// Expression that must never be true while the block is out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion lbl failed");

`endif

/* rtl/mp3sfe_pkg.sv */
// Package with the types, constants and tables of the scalefactor exponent block.
`default_nettype none

package mp3sfe_pkg;

  localparam int unsigned PREEMPH_ENTRIES = 22;
  localparam int unsigned BAND_INDEX_MAX = 21;

  localparam logic [10:0] GAIN_OFFSET = 11'd211;
  localparam logic [9:0]  MIXED_LONG_LINES = 10'd36;
  localparam logic [9:0]  LINE_COUNT_RESET = 10'd576;

  localparam logic [1:0] PREEMPH_TAB [PREEMPH_ENTRIES] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd2, 2'd0
  };

  typedef enum logic [2:0] {
    REG_GRAN_GAIN   = 3'd0,
    REG_SF_SHIFT    = 3'd1,
    REG_PREFLAG     = 3'd2,
    REG_BLOCK_SHORT = 3'd3,
    REG_MIXED_BLOCK = 3'd4,
    REG_WIN_GAINS   = 3'd5,
    REG_LINE_COUNT  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] gran_gain;
    logic       sf_shift_sel;
    logic       preflag;
    logic       block_short;
    logic       mixed_block;
    logic [8:0] win_gains;
    logic [9:0] line_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{line_count: LINE_COUNT_RESET, default: '0};

  typedef struct packed {
    logic [9:0] line_pos;
    logic [4:0] band_idx;
    logic [1:0] win_idx;
  } gran_state_t;

endpackage

`default_nettype wire

/* rtl/mp3_scalefactor_exponent_gen_top.sv */
// Top level of the Layer III scalefactor band exponent generator with its register port.
`default_nettype none
`include "assert_macros.svh"

// This block turns a stream of scalefactor band descriptors (a scalefactor and the
// band width in spectral lines) into requantization exponents in quarter powers of two,
// one result transaction per input transaction, in order. A long band yields
// gain - 211 - ((scale_factor + preemphasis) << m), a short window yields
// gain - 211 - 8 * window_gain - (scale_factor << m), where gain is the granule gain
// register, window_gain is the 3-bit gain of the current short window, and m is 2 when
// the shift select register is set and 1 otherwise. The block keeps the line position,
// the band index (saturating at 21) and the short window index (cycling 0, 1, 2); with
// mixed blocks the bands below line 36 count as long. The transaction whose width
// brings the line position to line_count or past it carries last_band and returns all
// of that state to zero, so the next transaction starts a new granule. The sustained
// rate is one transaction per clock cycle while out_ready_i stays high; the band sits in
// the input register while one stage of adders and compares works on it, and it moves
// into the result register once that register is empty or is being emptied.
// While a finished result waits for out_ready_i the input register can take one more
// band; after that in_ready_o stays low until the result is taken.
// Registers sit at byte addresses 0 (granule gain), 4 (shift select, 1 for a shift of
// two), 8 (preflag), 12 (block_short), 16 (mixed_block), 20 (window gains, window 0 in
// bits 2..0) and 24 (line_count, reset 576); they should be written only while the
// block is idle, and writes leave the granule state alone.

module mp3_scalefactor_exponent_gen_top
  import mp3sfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  scale_factor_i,
  input  wire logic [7:0]  band_width_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [9:0]       exponent_o,
  output logic             last_band_o
);

  // Configuration registers.
  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  // Input stage, granule state and result stage.
  logic        in_vld_q;
  logic [3:0]  sf_q;
  logic [7:0]  bw_q;
  gran_state_t state_q, state_d;
  logic        out_vld_q;
  logic [9:0]  exp_q;
  logic        last_q;

  logic        in_load;
  logic        advance;
  logic [9:0]  exp_d;
  logic        last_d;

  // The register port always completes in its access phase.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_GRAN_GAIN:   cfg_d.gran_gain    = pwdata[7:0];
        REG_SF_SHIFT:    cfg_d.sf_shift_sel = pwdata[0];
        REG_PREFLAG:     cfg_d.preflag      = pwdata[0];
        REG_BLOCK_SHORT: cfg_d.block_short  = pwdata[0];
        REG_MIXED_BLOCK: cfg_d.mixed_block  = pwdata[0];
        REG_WIN_GAINS:   cfg_d.win_gains    = pwdata[8:0];
        REG_LINE_COUNT:  cfg_d.line_count   = pwdata[9:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // Reads of an address past the register list return zero.
  always_comb begin
    case (reg_idx)
      REG_GRAN_GAIN:   prdata = {24'd0, cfg_q.gran_gain};
      REG_SF_SHIFT:    prdata = {31'd0, cfg_q.sf_shift_sel};
      REG_PREFLAG:     prdata = {31'd0, cfg_q.preflag};
      REG_BLOCK_SHORT: prdata = {31'd0, cfg_q.block_short};
      REG_MIXED_BLOCK: prdata = {31'd0, cfg_q.mixed_block};
      REG_WIN_GAINS:   prdata = {23'd0, cfg_q.win_gains};
      REG_LINE_COUNT:  prdata = {22'd0, cfg_q.line_count};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The held band moves into the result register whenever that register is empty or
  // is being emptied in this cycle; the input register then frees up for a new band.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_load    = in_valid_i && in_ready_o;

  // The exponent and the next granule state are both taken from the band in the input
  // register and the state as it stands before that band is counted.
  mp3sfe_core u_core (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .scale_factor_i (sf_q),
    .band_width_i   (bw_q),
    .exponent_o     (exp_d),
    .last_band_o    (last_d),
    .state_o        (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_load) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      sf_q <= scale_factor_i;
      bw_q <= band_width_i;
    end
    if (advance) begin
      exp_q  <= exp_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign exponent_o  = exp_q;
  assign last_band_o = last_q;

  // The band index saturates, and the window index never leaves its three windows.
  `ASSERT_CLK(a_band_idx_sat, clk_i, rst_ni, state_q.band_idx <= 5'(BAND_INDEX_MAX))
  `ASSERT_NEVER(a_win_idx_range, clk_i, rst_ni, state_q.win_idx == 2'd3)
  // A band that closes the granule leaves the whole granule state at zero.
  `ASSERT_CLK(a_granule_restart, clk_i, rst_ni, (advance && last_d) |=> (state_q == '0))
  // The input side only stalls when both stages hold a band and the output is blocked.
  `ASSERT_CLK(a_stall_cause, clk_i, rst_ni, !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))

endmodule

`default_nettype wire

/* rtl/mp3sfe_core.sv */
// Combinational exponent and granule state update for one scalefactor band.
`default_nettype none

module mp3sfe_core
  import mp3sfe_pkg::*;
(
  input  wire cfg_t        cfg_i,
  input  wire gran_state_t state_i,
  input  wire logic [3:0]  scale_factor_i,
  input  wire logic [7:0]  band_width_i,
  output logic [9:0]       exponent_o,
  output logic             last_band_o,
  output gran_state_t      state_o
);

  logic               is_long;
  logic [1:0]         pre;
  logic [1:0]         win;
  logic [2:0]         sbg;
  logic [4:0]         long_sum;
  logic [6:0]         long_term;
  logic [5:0]         sf_scaled;
  logic [6:0]         short_term;
  logic [6:0]         term;
  logic signed [10:0] gain;
  logic signed [10:0] expo;
  logic [10:0]        next_pos;
  logic [1:0]         win_next;
  logic [4:0]         band_next;

  assign is_long = !cfg_i.block_short ||
                   (cfg_i.mixed_block && (state_i.line_pos < MIXED_LONG_LINES));

  // Band indexes saturate at the last table entry, so the guard only protects the table.
  always_comb begin
    pre = 2'd0;
    if (cfg_i.preflag && (32'(state_i.band_idx) < PREEMPH_ENTRIES)) begin
      pre = PREEMPH_TAB[state_i.band_idx];
    end
  end

  // A window index of three never occurs; it is treated as window zero.
  assign win = (state_i.win_idx > 2'd2) ? 2'd0 : state_i.win_idx;

  always_comb begin
    unique case (win)
      2'd1:    sbg = cfg_i.win_gains[5:3];
      2'd2:    sbg = cfg_i.win_gains[8:6];
      default: sbg = cfg_i.win_gains[2:0];
    endcase
  end

  assign long_sum  = {1'b0, scale_factor_i} + {3'b000, pre};
  assign long_term = cfg_i.sf_shift_sel ? {long_sum, 2'b00} : {1'b0, long_sum, 1'b0};
  assign sf_scaled = cfg_i.sf_shift_sel ? {scale_factor_i, 2'b00}
                                        : {1'b0, scale_factor_i, 1'b0};
  assign short_term = {1'b0, sbg, 3'b000} + {1'b0, sf_scaled};
  assign term       = is_long ? long_term : short_term;

  assign gain = $signed({3'b000, cfg_i.gran_gain}) - $signed(GAIN_OFFSET);
  assign expo = gain - $signed({4'b0000, term});
  assign exponent_o = expo[9:0];

  assign next_pos    = {1'b0, state_i.line_pos} + {3'b000, band_width_i};
  assign last_band_o = next_pos >= {1'b0, cfg_i.line_count};

  assign win_next  = is_long ? state_i.win_idx : ((win >= 2'd2) ? 2'd0 : win + 2'd1);
  assign band_next = (32'(state_i.band_idx) < BAND_INDEX_MAX) ? state_i.band_idx + 5'd1
                                                              : state_i.band_idx;

  always_comb begin
    if (last_band_o) begin
      state_o = '0;
    end else begin
      state_o.line_pos = next_pos[9:0];
      state_o.band_idx = band_next;
      state_o.win_idx  = win_next;
    end
  end

endmodule

`default_nettype wire
